>>> hw/rtl/nccm_pkg.sv
// ----------------------------------------------------------------------------
// Normalization cube map package
// Shared types, fixed-point constants and the per-face direction function.
// ----------------------------------------------------------------------------
package nccm_pkg;

	// Coordinates and vector components are signed Q2.16.
	localparam int unsigned COMP_W   = 18;
	localparam int unsigned NUM_W    = 28;   // u * 2^17 + (d >> 1)
	localparam int unsigned RECIP_SH = 28;   // reciprocal scale 2^28
	localparam int unsigned RECIP_W  = 29;   // floor(2^28 / d) with d >= 1
	localparam int unsigned QUO_W    = 18;   // coordinate quotient 0..2^17
	localparam int unsigned SQ_W     = 33;   // one squared component
	localparam int unsigned LEN_W    = 34;   // sum of three squares
	localparam int unsigned ROOT_W   = 31;   // floor(sqrt(L * 2^28))
	localparam int unsigned REM_W    = 33;   // square root remainder
	localparam int unsigned ENC_W    = 41;   // 255 * (C + R)
	localparam int unsigned DIV_W    = 32;   // 2 * R

	localparam logic [QUO_W-1:0]          ONE_Q16    = 18'd65536;
	localparam logic [QUO_W-1:0]          Q_MAX      = 18'd131072;
	localparam logic signed [COMP_W-1:0]  POS_ONE    = 18'sd65536;
	localparam logic signed [COMP_W-1:0]  NEG_ONE    = -18'sd65536;
	localparam logic [7:0]                UNDEF_BYTE = 8'd127;

	// Face codes.
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	// Direction vector handed from the front to the back.
	typedef struct packed {
		logic                      zero;
		logic signed [COMP_W-1:0]  x;
		logic signed [COMP_W-1:0]  y;
		logic signed [COMP_W-1:0]  z;
	} vec_t;

	// Forms axis + a*s + b*t for a face. Each component takes exactly one
	// term, so the tables reduce to a selection with signs.
	function automatic vec_t face_vec(input logic [2:0] face,
	                                  input logic signed [COMP_W-1:0] a,
	                                  input logic signed [COMP_W-1:0] b);
		vec_t v;
		v.zero = 1'b0;
		v.x    = '0;
		v.y    = '0;
		v.z    = '0;
		unique case (face)
			FACE_POS_X: begin
				v.x = POS_ONE; v.y = -b; v.z = -a;
			end
			FACE_NEG_X: begin
				v.x = NEG_ONE; v.y = -b; v.z = a;
			end
			FACE_POS_Y: begin
				v.x = a; v.y = POS_ONE; v.z = b;
			end
			FACE_NEG_Y: begin
				v.x = a; v.y = NEG_ONE; v.z = -b;
			end
			FACE_POS_Z: begin
				v.x = a; v.y = -b; v.z = POS_ONE;
			end
			FACE_NEG_Z: begin
				v.x = -a; v.y = -b; v.z = NEG_ONE;
			end
			default: begin
				v.zero = 1'b1;
			end
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/normalization_cubemap_texel_unit.sv
// ----------------------------------------------------------------------------
// Normalization cube map texel unit
// Encodes the unit direction of one cube map texel as an RGB byte triple.
// ----------------------------------------------------------------------------
// A request (face, column, row) is taken whenever start is high and busy is
// low, one per clock cycle. Its red, green and blue bytes appear for one
// cycle, with done high; the receiver cannot stall, and transactions come
// out in request order. The back end holds the 31-stage square root and the
// 8-stage encode divider. After reset and after every face_size write, busy
// stays high while the reciprocal of the face size is computed one bit per
// cycle.
module normalization_cubemap_texel_unit #(
	parameter int unsigned MAX_FACE_SIZE = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,
	input  logic         start,
	output logic         busy,
	input  logic [2:0]   face,
	input  logic [9:0]   column,
	input  logic [9:0]   row,
	output logic         done,
	output logic [7:0]   red,
	output logic [7:0]   green,
	output logic [7:0]   blue
);

	logic              push;
	nccm_pkg::vec_t    push_data;
	logic              not_empty;
	nccm_pkg::vec_t    head;

	nccm_front #(.MAX_FACE_SIZE(MAX_FACE_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.face      (face),
		.column    (column),
		.row       (row),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	nccm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (1'b1),
		.not_empty (not_empty),
		.head      (head)
	);

	nccm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (not_empty),
		.in_vec (head),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule

>>> hw/rtl/nccm_recip.sv
// ----------------------------------------------------------------------------
// Reciprocal unit
// Iterative restoring division giving floor(2^28 / d), one bit per cycle.
// ----------------------------------------------------------------------------
module nccm_recip #(
	parameter int unsigned DW = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic [DW-1:0]                      divisor,
	output logic                               running,
	output logic [nccm_pkg::RECIP_W-1:0]       recip
);

	logic [4:0]                        cnt_q;
	logic                              run_q;
	logic [DW:0]                       rem_q;
	logic [nccm_pkg::RECIP_W-1:0]      quo_q;
	logic [DW:0]                       rem_sh;
	logic                              ge;

	// One shift-and-subtract step; the dividend has only bit 28 set.
	always_comb begin
		rem_sh = {rem_q[DW-1:0], (cnt_q == 5'(nccm_pkg::RECIP_SH))};
		ge     = rem_sh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 5'(nccm_pkg::RECIP_SH);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
			quo_q <= {quo_q[nccm_pkg::RECIP_W-2:0], ge};
		end
	end

	assign running = run_q;
	assign recip   = quo_q;

endmodule

>>> hw/rtl/nccm_front.sv
// ----------------------------------------------------------------------------
// Front end
// Holds the face size, accepts texel requests and maps column and row to
// Q2.16 coordinates by reciprocal multiplication, then forms the vector.
// ----------------------------------------------------------------------------
module nccm_front #(
	parameter int unsigned MAX_FACE_SIZE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [10:0]          cfg_wdata,
	input  logic                 start,
	input  logic [2:0]           face,
	input  logic [9:0]           column,
	input  logic [9:0]           row,
	output logic                 busy,
	output logic                 push,
	output nccm_pkg::vec_t       push_data
);

	localparam int unsigned DW  = $clog2(MAX_FACE_SIZE);
	localparam int unsigned SW  = $clog2(MAX_FACE_SIZE + 1);
	localparam int unsigned CW  = (SW > 11) ? SW : 11;
	localparam int unsigned IW  = (DW > 10) ? DW : 10;
	localparam int unsigned PW  = nccm_pkg::NUM_W + nccm_pkg::RECIP_W;
	localparam int unsigned QW  = nccm_pkg::QUO_W;
	localparam int unsigned NW  = nccm_pkg::NUM_W;

	logic [10:0]                   face_size_q;
	logic                          pend_q;
	logic                          recip_run;
	logic [nccm_pkg::RECIP_W-1:0]  recip;
	logic [CW-1:0]                 size_c;
	logic [DW-1:0]                 d;
	logic                          accept;
	logic [9:0]                    u_sat, v_sat;

	// Face size register; a new value reruns the reciprocal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= 11'd64;
			pend_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				face_size_q <= cfg_wdata;
			end
			pend_q <= cfg_we;
		end
	end

	// Effective size clamped to 2..MAX_FACE_SIZE, and d = size - 1.
	always_comb begin
		if (CW'(face_size_q) < CW'(2)) begin
			size_c = CW'(2);
		end else if (CW'(face_size_q) > CW'(MAX_FACE_SIZE)) begin
			size_c = CW'(MAX_FACE_SIZE);
		end else begin
			size_c = CW'(face_size_q);
		end
		d = DW'(size_c - CW'(1));
	end

	nccm_recip #(.DW(DW)) u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (pend_q),
		.divisor (d),
		.running (recip_run),
		.recip   (recip)
	);

	assign busy   = pend_q | recip_run;
	assign accept = start & ~busy;

	// Indices past the face edge saturate to d.
	always_comb begin
		u_sat = (IW'(column) > IW'(d)) ? 10'(d) : column;
		v_sat = (IW'(row) > IW'(d)) ? 10'(d) : row;
	end

	// Stage 1: rounded numerators.
	logic           vld_s1;
	logic [2:0]     face_s1;
	logic [NW-1:0]  numa_s1, numb_s1;

	// Stage 2: quotient estimates from the reciprocal.
	logic           vld_s2;
	logic [2:0]     face_s2;
	logic [NW-1:0]  numa_s2, numb_s2;
	logic [QW-1:0]  qa_s2, qb_s2;
	logic [PW-1:0]  pa, pb;

	// Stage 3: back products for the correction step.
	logic           vld_s3;
	logic [2:0]     face_s3;
	logic [NW-1:0]  numa_s3, numb_s3;
	logic [QW-1:0]  qa_s3, qb_s3;
	logic [NW-1:0]  qda_s3, qdb_s3;

	always_comb begin
		pa = PW'(numa_s1) * PW'(recip);
		pb = PW'(numb_s1) * PW'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		face_s1 <= face;
		numa_s1 <= {1'b0, u_sat, 17'b0} + NW'(d >> 1);
		numb_s1 <= {1'b0, v_sat, 17'b0} + NW'(d >> 1);
		face_s2 <= face_s1;
		numa_s2 <= numa_s1;
		numb_s2 <= numb_s1;
		qa_s2   <= pa[nccm_pkg::RECIP_SH +: QW];
		qb_s2   <= pb[nccm_pkg::RECIP_SH +: QW];
		face_s3 <= face_s2;
		numa_s3 <= numa_s2;
		numb_s3 <= numb_s2;
		qa_s3   <= qa_s2;
		qb_s3   <= qb_s2;
		qda_s3  <= NW'(NW'(qa_s2) * NW'(d));
		qdb_s3  <= NW'(NW'(qb_s2) * NW'(d));
	end

	// Correction: the estimate is at most one low.
	logic [NW-1:0]               rema, remb;
	logic [QW-1:0]               qa, qb;
	logic signed [QW-1:0]        a, b;

	always_comb begin
		rema = numa_s3 - qda_s3;
		remb = numb_s3 - qdb_s3;
		qa   = qa_s3 + QW'(rema >= NW'(d));
		qb   = qb_s3 + QW'(remb >= NW'(d));
		a    = $signed(qa - nccm_pkg::ONE_Q16);
		b    = $signed(qb - nccm_pkg::ONE_Q16);
	end

	assign push      = vld_s3;
	assign push_data = nccm_pkg::face_vec(face_s3, a, b);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		recip_run |-> !accept)
		else $error("request taken while reciprocal runs");
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (qa <= nccm_pkg::Q_MAX) && (qb <= nccm_pkg::Q_MAX))
		else $error("coordinate quotient out of range");

endmodule

>>> hw/rtl/nccm_queue.sv
// ----------------------------------------------------------------------------
// Vector queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module nccm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nccm_pkg::vec_t    push_data,
	input  logic              pop,
	output logic              not_empty,
	output nccm_pkg::vec_t    head
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);

	nccm_pkg::vec_t    mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	logic              do_pop;

	assign not_empty = cnt_q != '0;
	assign do_pop    = pop & not_empty;
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < (AW+1)'(DEPTH)) || do_pop)
		else $error("queue overflow");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count out of range");

endmodule

>>> hw/rtl/nccm_back.sv
// ----------------------------------------------------------------------------
// Back end
// Squares and sums the vector, takes a pipelined square root one bit per
// stage, and encodes each component by a pipelined eight-step division.
// ----------------------------------------------------------------------------
module nccm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  nccm_pkg::vec_t    in_vec,
	output logic              done,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);

	localparam int unsigned CW  = nccm_pkg::COMP_W;
	localparam int unsigned NS  = nccm_pkg::ROOT_W;   // square root stages
	localparam int unsigned ND  = 8;                  // division stages

	// Stage 1: squares.
	logic                 vld_s1;
	nccm_pkg::vec_t       vec_s1;
	logic [nccm_pkg::SQ_W-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [2*CW-1:0]    px, py, pz;

	always_comb begin
		px = in_vec.x * in_vec.x;
		py = in_vec.y * in_vec.y;
		pz = in_vec.z * in_vec.z;
	end

	// Square root pipeline; element zero holds the summed length.
	logic                          vld_s  [NS+1];
	nccm_pkg::vec_t                vec_s  [NS+1];
	logic [nccm_pkg::LEN_W-1:0]    len_s  [NS+1];
	logic [NS-1:0]                 root_s [NS+1];
	logic [nccm_pkg::REM_W-1:0]    rem_s  [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1    <= in_vec;
		sqx_s1    <= px[nccm_pkg::SQ_W-1:0];
		sqy_s1    <= py[nccm_pkg::SQ_W-1:0];
		sqz_s1    <= pz[nccm_pkg::SQ_W-1:0];
		vec_s[0]  <= vec_s1;
		len_s[0]  <= nccm_pkg::LEN_W'(sqx_s1) + nccm_pkg::LEN_W'(sqy_s1)
		           + nccm_pkg::LEN_W'(sqz_s1);
		root_s[0] <= '0;
		rem_s[0]  <= '0;
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		localparam int unsigned I = NS - 1 - j;
		logic [61:0]  x_w;
		logic [34:0]  rsh, trial;
		logic         ge;

		// One digit of the bit-pair square root on L * 2^28.
		always_comb begin
			x_w   = {len_s[j], 28'b0};
			rsh   = {rem_s[j], x_w[2*I+1 -: 2]};
			trial = 35'({root_s[j], 2'b01});
			ge    = rsh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			vec_s[j+1]  <= vec_s[j];
			len_s[j+1]  <= len_s[j];
			root_s[j+1] <= {root_s[j][NS-2:0], ge};
			rem_s[j+1]  <= nccm_pkg::REM_W'(ge ? rsh - trial : rsh);
		end
	end

	// Encode pipeline: numerators 255 * (C + R), divisor 2 * R.
	logic                          vld_e [ND+1];
	logic                          zf_e  [ND+1];
	logic [nccm_pkg::DIV_W-1:0]    d_e   [ND+1];
	logic [nccm_pkg::ENC_W-1:0]    n_e   [3][ND+1];
	logic [7:0]                    q_e   [3][ND+1];
	logic signed [CW-1:0]          comp  [3];
	logic [32:0]                   cr    [3];

	always_comb begin
		comp[0] = vec_s[NS].x;
		comp[1] = vec_s[NS].y;
		comp[2] = vec_s[NS].z;
		for (int k = 0; k < 3; k++) begin
			cr[k] = 33'($signed({comp[k], 14'b0}) + $signed({3'b0, root_s[NS]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e[0] <= 1'b0;
		end else begin
			vld_e[0] <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		zf_e[0] <= vec_s[NS].zero;
		d_e[0]  <= {root_s[NS], 1'b0};
		for (int k = 0; k < 3; k++) begin
			n_e[k][0] <= {cr[k], 8'b0} - nccm_pkg::ENC_W'(cr[k]);
			q_e[k][0] <= '0;
		end
	end

	for (genvar t = 0; t < ND; t++) begin : g_div
		localparam int unsigned SH = ND - 1 - t;
		logic [nccm_pkg::ENC_W-1:0] dsh;
		logic                       ge [3];

		// One quotient bit per component.
		always_comb begin
			dsh = nccm_pkg::ENC_W'(d_e[t]) << SH;
			for (int k = 0; k < 3; k++) begin
				ge[k] = n_e[k][t] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_e[t+1] <= 1'b0;
			end else begin
				vld_e[t+1] <= vld_e[t];
			end
		end

		always_ff @(posedge clk) begin
			zf_e[t+1] <= zf_e[t];
			d_e[t+1]  <= d_e[t];
			for (int k = 0; k < 3; k++) begin
				n_e[k][t+1] <= ge[k] ? n_e[k][t] - dsh : n_e[k][t];
				q_e[k][t+1] <= q_e[k][t] | (8'(ge[k]) << SH);
			end
		end
	end

	// Output register; an undefined face gives mid-gray.
	logic        done_q;
	logic [7:0]  red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_e[ND];
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= zf_e[ND] ? nccm_pkg::UNDEF_BYTE : q_e[0][ND];
		green_q <= zf_e[ND] ? nccm_pkg::UNDEF_BYTE : q_e[1][ND];
		blue_q  <= zf_e[ND] ? nccm_pkg::UNDEF_BYTE : q_e[2][ND];
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS] |-> ((root_s[NS] == '0) == vec_s[NS].zero))
		else $error("root is zero exactly for the undefined face");

endmodule

>>> dv/normalization_cubemap_texel_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalization cube map texel unit testbench
// Sends texel requests over several face sizes and compares every RGB
// transaction against a fixed-point direction and normalization predictor.
// ----------------------------------------------------------------------------
module normalization_cubemap_texel_unit_tb;

	localparam int unsigned MAX_SIZE   = 1024;
	localparam int          LATENCY    = 47;
	localparam int          SETTLE     = LATENCY + 20;
	localparam longint      CYCLE_CAP  = 400000;
	localparam int          NUM_RANDOM = 930;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic [2:0]  face;
	logic [9:0]  column;
	logic [9:0]  row;
	logic        done;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	rgb_t        pending_texels[$];
	logic [10:0] model_face_size;
	int          error_count;
	int          idle_pct;
	longint      cycle_count;

	normalization_cubemap_texel_unit #(
		.MAX_FACE_SIZE(MAX_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.face(face),
		.column(column),
		.row(row),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Integer square root, floor(sqrt(x)).
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Texel index to signed Q2.16 in [-1, 1], rounded half up.
	function automatic longint texel_coord(input longint idx, input longint size);
		longint d;
		d = size - 1;
		if (idx > d)
			idx = d;
		return (idx * 131072 + d / 2) / d - 65536;
	endfunction

	// One component to its byte: floor(255 * (C + R) / (2R)), clamped.
	function automatic logic [7:0] encode_comp(input longint comp,
	                                           input longint unsigned root);
		longint unsigned num;
		longint unsigned q;
		if (root == 0)
			return 8'd127;
		num = longint'(comp * 16384 + longint'(root)) * 255;
		q   = num / (2 * root);
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// Direction for a face, normalized and encoded as RGB.
	function automatic rgb_t predict_texel(input logic [2:0] f, input logic [9:0] u,
	                                       input logic [9:0] v, input logic [10:0] cfg);
		longint          size;
		longint          a;
		longint          b;
		longint          vx;
		longint          vy;
		longint          vz;
		longint unsigned len2;
		longint unsigned root;
		rgb_t            res;
		size = cfg;
		if (size < 2)
			size = 2;
		if (size > MAX_SIZE)
			size = MAX_SIZE;
		a  = texel_coord(u, size);
		b  = texel_coord(v, size);
		vx = 0;
		vy = 0;
		vz = 0;
		case (f)
			nccm_pkg::FACE_POS_X: begin
				vx = 65536; vy = -b; vz = -a;
			end
			nccm_pkg::FACE_NEG_X: begin
				vx = -65536; vy = -b; vz = a;
			end
			nccm_pkg::FACE_POS_Y: begin
				vx = a; vy = 65536; vz = b;
			end
			nccm_pkg::FACE_NEG_Y: begin
				vx = a; vy = -65536; vz = -b;
			end
			nccm_pkg::FACE_POS_Z: begin
				vx = a; vy = -b; vz = 65536;
			end
			nccm_pkg::FACE_NEG_Z: begin
				vx = -a; vy = -b; vz = -65536;
			end
			default: begin
			end
		endcase
		len2      = vx * vx + vy * vy + vz * vz;
		root      = int_sqrt(len2 << 28);
		res.red   = encode_comp(vx, root);
		res.green = encode_comp(vy, root);
		res.blue  = encode_comp(vz, root);
		return res;
	endfunction

	// Optional sender gap, with start lowered.
	task automatic sender_gap();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Sends one request and records its expected transaction once accepted.
	task automatic send_texel(input logic [2:0] f, input logic [9:0] u,
	                          input logic [9:0] v);
		sender_gap();
		start  <= 1'b1;
		face   <= f;
		column <= u;
		row    <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_texels.push_back(predict_texel(f, u, v, model_face_size));
	endtask

	// Waits until every expected transaction has come back.
	task automatic drain();
		start <= 1'b0;
		while (pending_texels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes face_size with the block idle.
	task automatic write_face_size(input logic [10:0] value);
		drain();
		cfg_we          <= 1'b1;
		cfg_wdata       <= value;
		model_face_size = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Face corners, centers, out-of-face indices, undefined faces and out-of-range face sizes.
	task automatic test_directed();
		idle_pct = 0;
		send_texel(nccm_pkg::FACE_POS_X, 10'd0, 10'd0);
		send_texel(nccm_pkg::FACE_NEG_X, 10'd63, 10'd63);
		send_texel(nccm_pkg::FACE_POS_Y, 10'd0, 10'd63);
		send_texel(nccm_pkg::FACE_NEG_Y, 10'd63, 10'd0);
		send_texel(nccm_pkg::FACE_POS_Z, 10'd31, 10'd32);
		send_texel(nccm_pkg::FACE_NEG_Z, 10'd1023, 10'd1023);
		send_texel(3'd6, 10'd5, 10'd9);
		send_texel(3'd7, 10'd1023, 10'd0);
		write_face_size(11'd2);
		send_texel(nccm_pkg::FACE_POS_X, 10'd1, 10'd0);
		send_texel(nccm_pkg::FACE_NEG_Z, 10'd0, 10'd1);
		write_face_size(11'd0);
		send_texel(nccm_pkg::FACE_POS_Y, 10'd1, 10'd1);
		write_face_size(11'd1);
		send_texel(nccm_pkg::FACE_NEG_Y, 10'd0, 10'd1);
		write_face_size(11'd2047);
		send_texel(nccm_pkg::FACE_POS_Z, 10'd1023, 10'd0);
		send_texel(nccm_pkg::FACE_NEG_X, 10'd511, 10'd512);
		write_face_size(11'd1024);
		send_texel(nccm_pkg::FACE_POS_X, 10'd1023, 10'd1023);
		send_texel(nccm_pkg::FACE_NEG_Y, 10'd0, 10'd511);
		write_face_size(11'd1025);
		send_texel(nccm_pkg::FACE_POS_Y, 10'd1023, 10'd256);
		write_face_size(11'd3);
		send_texel(nccm_pkg::FACE_NEG_X, 10'd1, 10'd2);
		send_texel(nccm_pkg::FACE_POS_Z, 10'd700, 10'd1);
		drain();
	endtask

	// Random requests over listed and random face sizes and sender idling phases.
	task automatic test_random();
		logic [10:0] sizes[8];
		logic [2:0]  f;
		logic [10:0] sz;
		logic [9:0]  u;
		logic [9:0]  v;
		sizes = '{11'd2, 11'd1024, 11'd64, 11'd5, 11'd0, 11'd2047, 11'd17, 11'd300};
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i < NUM_RANDOM / 3)
				idle_pct = 7;
			else if (i < 2 * NUM_RANDOM / 3)
				idle_pct = 87;
			else
				idle_pct = 0;
			if (i % 80 == 0) begin
				if (i / 80 < 8)
					write_face_size(sizes[i / 80]);
				else
					write_face_size(11'($urandom));
			end
			sz = (model_face_size < 2) ? 11'd2 :
			     (model_face_size > MAX_SIZE) ? 11'(MAX_SIZE) : model_face_size;
			f = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) :
			                               3'($urandom_range(5));
			if ($urandom_range(9) == 0) begin
				u = 10'($urandom);
				v = 10'($urandom);
			end else begin
				u = 10'($urandom_range(sz - 1));
				v = 10'($urandom_range(sz - 1));
			end
			send_texel(f, u, v);
			// Hold off until the pipe is empty once in a while.
			if (i % 150 == 75)
				drain();
		end
		drain();
	endtask

	// Checks each result transaction against the oldest expectation.
	always @(posedge clk) begin
		rgb_t exp_rgb;
		if (arst_n && done) begin
			if (pending_texels.size() == 0) begin
				$error("unexpected transaction: red %0d green %0d blue %0d",
				       red, green, blue);
				error_count++;
			end else begin
				exp_rgb = pending_texels.pop_front();
				if (red !== exp_rgb.red) begin
					$error("red: expected %0d, actual %0d", exp_rgb.red, red);
					error_count++;
				end
				if (green !== exp_rgb.green) begin
					$error("green: expected %0d, actual %0d", exp_rgb.green, green);
					error_count++;
				end
				if (blue !== exp_rgb.blue) begin
					$error("blue: expected %0d, actual %0d", exp_rgb.blue, blue);
					error_count++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		start           = 1'b0;
		face            = '0;
		column          = '0;
		row             = '0;
		model_face_size = 11'd64;
		error_count     = 0;
		idle_pct        = 0;
		cycle_count     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/nccm_pkg.sv
hw/rtl/nccm_recip.sv
hw/rtl/nccm_front.sv
hw/rtl/nccm_queue.sv
hw/rtl/nccm_back.sv
hw/rtl/normalization_cubemap_texel_unit.sv
dv/normalization_cubemap_texel_unit_tb.sv
